// ----- design/smv_pkg.sv -----
// ----------------------------------------------------------------------------
// smv_pkg
// shared types and constants for the smooth vertex normal block
// ----------------------------------------------------------------------------
package smv_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [17:0] {
    ST_CLEAR  = 18'h00001,
    ST_IDLE   = 18'h00002,
    ST_RD0    = 18'h00004,
    ST_RD1    = 18'h00008,
    ST_RD2    = 18'h00010,
    ST_RD3    = 18'h00020,
    ST_SCALE  = 18'h00040,
    ST_CROSS  = 18'h00080,
    ST_UINIT  = 18'h00100,
    ST_NORM   = 18'h00200,
    ST_SQ     = 18'h00400,
    ST_SQRT   = 18'h00800,
    ST_DINIT  = 18'h01000,
    ST_DIV    = 18'h02000,
    ST_ACC_RD = 18'h04000,
    ST_ACC_WR = 18'h08000,
    ST_RDACC  = 18'h10000,
    ST_RESULT = 18'h20000
  } state_e;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned NRM_W   = 16;
  localparam int unsigned EDGE_W  = 34;
  localparam int unsigned VEC_W   = 62;
  localparam int unsigned REM_W   = 46;
  localparam int unsigned QUO_W   = 15;
  localparam int unsigned UNIT_ONE = 16384;

endpackage

// ----- design/smooth_vertex_normals.sv -----
// ----------------------------------------------------------------------------
// smooth_vertex_normals
// per-vertex averaged normals of a triangle mesh on one shared datapath
// ----------------------------------------------------------------------------
// triangle adds and reads run through the bit-serial square root (32 steps) and
// the restoring divider, one component at a time, except for a degenerate face
// or the default normal; one item in flight, input stalls until it retires and
// while a result waits.
// after reset a clearing pass zeroes the accumulators, input stalls meanwhile;
// configuration writes are always taken.
// ----------------------------------------------------------------------------
module smooth_vertex_normals #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned ACCUM_BITS   = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [9:0]  vertex_a_i,
  input  logic [9:0]  vertex_b_i,
  input  logic [9:0]  vertex_c_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  normal_index_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_reverse_winding_i
);

  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned AB  = ACCUM_BITS;
  localparam int unsigned VW  = smv_pkg::VEC_W;
  localparam int unsigned EW  = smv_pkg::EDGE_W;
  localparam int unsigned RW  = smv_pkg::REM_W;
  localparam int unsigned QW  = smv_pkg::QUO_W;
  localparam int unsigned NW  = smv_pkg::NRM_W;

  smv_pkg::state_e state_q, state_d;

  logic              rev_q;
  logic [AW-1:0]     clr_q;
  logic [AW-1:0]     ca_q, cb_q, cc_q;
  logic              tri_q;
  logic [9:0]        idx_q;
  logic [95:0]       pa_q, pb_q;
  logic signed [EW-1:0] e_q [6];
  logic signed [VW-1:0] v_q [3];
  logic [VW-1:0]     m_q [3];
  logic [2:0]        sgn_q;
  logic signed [63:0] prod_q;
  logic [63:0]       sum_q;
  logic [63:0]       x_q, r_q, bit_q;
  logic [31:0]       mag_q;
  logic [RW-1:0]     rem_q;
  logic [QW-1:0]     quo_q;
  logic [4:0]        cnt_q;
  logic [1:0]        comp_q;
  logic signed [NW-1:0] n_q [3];
  logic              out_valid_q;
  logic [9:0]        out_idx_q;
  logic signed [NW-1:0] out_n_q [3];

  logic        accept;
  logic [16:0] va_w, vb_w, vc_w;
  logic        a_ok, b_ok, c_ok;
  logic        out_free;

  logic          node_we;
  logic [AW-1:0] node_waddr, node_raddr;
  logic [95:0]   node_wdata, node_rdata;
  logic          acc_we;
  logic [AW-1:0] acc_waddr, acc_raddr;
  logic [3*AB-1:0] acc_wdata, acc_rdata;

  logic [AW-1:0] corner;
  logic [1:0]    cross_sel;
  logic signed [31:0] mul_a, mul_b;
  logic [VW-1:0] mx;
  logic          big;
  logic [63:0]   sq_try;
  logic [RW-1:0] div_d;
  logic signed [AB:0] sat_s [3];
  logic signed [AB-1:0] sat_r [3];

  assign va_w = 17'(vertex_a_i);
  assign vb_w = 17'(vertex_b_i);
  assign vc_w = 17'(vertex_c_i);
  assign a_ok = va_w < 17'(MAX_VERTICES);
  assign b_ok = vb_w < 17'(MAX_VERTICES);
  assign c_ok = vc_w < 17'(MAX_VERTICES);

  assign in_stall_o  = (state_q != smv_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cross_sel   = 2'((cnt_q - 5'd1) >> 1);

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    corner = ca_q;
      2'd1:    corner = cb_q;
      default: corner = cc_q;
    endcase
  end

  // memory port selection
  always_comb begin
    node_we    = accept && (command_i == smv_pkg::CMD_LOAD) && a_ok;
    node_waddr = va_w[AW-1:0];
    node_wdata = {pos_z_i, pos_y_i, pos_x_i};
    case (state_q)
      smv_pkg::ST_RD1: node_raddr = cb_q;
      smv_pkg::ST_RD2: node_raddr = cc_q;
      default:         node_raddr = ca_q;
    endcase
    acc_we    = 1'b0;
    acc_waddr = va_w[AW-1:0];
    acc_wdata = '0;
    acc_raddr = va_w[AW-1:0];
    case (state_q)
      smv_pkg::ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_q;
      end
      smv_pkg::ST_IDLE: begin
        acc_we = node_we;
      end
      smv_pkg::ST_ACC_RD: begin
        acc_raddr = corner;
      end
      smv_pkg::ST_ACC_WR: begin
        acc_we    = 1'b1;
        acc_waddr = corner;
        acc_wdata = {sat_r[2], sat_r[1], sat_r[0]};
      end
      default: ;
    endcase
  end

  // saturating accumulate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_s[i] = (AB+1)'($signed(acc_rdata[i*AB +: AB])) + (AB+1)'(n_q[i]);
      if (sat_s[i][AB] != sat_s[i][AB-1]) begin
        sat_r[i] = sat_s[i][AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
      end else begin
        sat_r[i] = sat_s[i][AB-1:0];
      end
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == smv_pkg::ST_CROSS) begin
      case (cnt_q)
        5'd0: begin mul_a = 32'(e_q[1]); mul_b = 32'(e_q[5]); end
        5'd1: begin mul_a = 32'(e_q[2]); mul_b = 32'(e_q[4]); end
        5'd2: begin mul_a = 32'(e_q[2]); mul_b = 32'(e_q[3]); end
        5'd3: begin mul_a = 32'(e_q[0]); mul_b = 32'(e_q[5]); end
        5'd4: begin mul_a = 32'(e_q[0]); mul_b = 32'(e_q[4]); end
        5'd5: begin mul_a = 32'(e_q[1]); mul_b = 32'(e_q[3]); end
        default: ;
      endcase
    end else begin
      case (cnt_q)
        5'd0: begin mul_a = $signed({2'b0, m_q[0][29:0]}); mul_b = mul_a; end
        5'd1: begin mul_a = $signed({2'b0, m_q[1][29:0]}); mul_b = mul_a; end
        5'd2: begin mul_a = $signed({2'b0, m_q[2][29:0]}); mul_b = mul_a; end
        default: ;
      endcase
    end
  end

  always_comb begin
    mx = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
    big = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (e_q[i] >= EW'(64'sd1073741824) || e_q[i] <= -EW'(64'sd1073741824)) big = 1'b1;
    end
    sq_try = r_q + bit_q;
    div_d  = RW'(mag_q) << cnt_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      smv_pkg::ST_CLEAR:  if (clr_q == AW'(MAX_VERTICES - 1)) state_d = smv_pkg::ST_IDLE;
      smv_pkg::ST_IDLE: begin
        if (accept) begin
          case (command_i)
            smv_pkg::CMD_TRI:  if (a_ok && b_ok && c_ok) state_d = smv_pkg::ST_RD0;
            smv_pkg::CMD_READ: state_d = a_ok ? smv_pkg::ST_RDACC : smv_pkg::ST_RESULT;
            default: ;
          endcase
        end
      end
      smv_pkg::ST_RD0:    state_d = smv_pkg::ST_RD1;
      smv_pkg::ST_RD1:    state_d = smv_pkg::ST_RD2;
      smv_pkg::ST_RD2:    state_d = smv_pkg::ST_RD3;
      smv_pkg::ST_RD3:    state_d = smv_pkg::ST_SCALE;
      smv_pkg::ST_SCALE:  if (!big) state_d = smv_pkg::ST_CROSS;
      smv_pkg::ST_CROSS:  if (cnt_q == 5'd6) state_d = smv_pkg::ST_UINIT;
      smv_pkg::ST_RDACC:  state_d = smv_pkg::ST_UINIT;
      smv_pkg::ST_UINIT: begin
        if (v_q[0] == '0 && v_q[1] == '0 && v_q[2] == '0) begin
          state_d = tri_q ? smv_pkg::ST_IDLE : smv_pkg::ST_RESULT;
        end else begin
          state_d = smv_pkg::ST_NORM;
        end
      end
      smv_pkg::ST_NORM: begin
        if (mx < VW'(64'd1 << 30) && mx >= VW'(64'd1 << 29)) state_d = smv_pkg::ST_SQ;
      end
      smv_pkg::ST_SQ:     if (cnt_q == 5'd3) state_d = smv_pkg::ST_SQRT;
      smv_pkg::ST_SQRT:   if (bit_q == 64'd1) state_d = smv_pkg::ST_DINIT;
      smv_pkg::ST_DINIT:  state_d = smv_pkg::ST_DIV;
      smv_pkg::ST_DIV: begin
        if (cnt_q == 5'd0) begin
          if (comp_q != 2'd2) state_d = smv_pkg::ST_DINIT;
          else state_d = tri_q ? smv_pkg::ST_ACC_RD : smv_pkg::ST_RESULT;
        end
      end
      smv_pkg::ST_ACC_RD: state_d = smv_pkg::ST_ACC_WR;
      smv_pkg::ST_ACC_WR: state_d = (cnt_q == 5'd2) ? smv_pkg::ST_IDLE : smv_pkg::ST_ACC_RD;
      smv_pkg::ST_RESULT: if (out_free) state_d = smv_pkg::ST_IDLE;
      default:            state_d = smv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smv_pkg::ST_CLEAR;
      rev_q       <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      comp_q      <= '0;
      tri_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) rev_q <= cfg_reverse_winding_i;
      if (state_q == smv_pkg::ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        smv_pkg::ST_CLEAR: clr_q <= clr_q + AW'(1);
        smv_pkg::ST_IDLE: begin
          cnt_q  <= '0;
          comp_q <= '0;
          tri_q  <= (command_i == smv_pkg::CMD_TRI);
          idx_q  <= vertex_a_i;
          ca_q   <= va_w[AW-1:0];
          cb_q   <= rev_q ? vc_w[AW-1:0] : vb_w[AW-1:0];
          cc_q   <= rev_q ? vb_w[AW-1:0] : vc_w[AW-1:0];
          n_q[0] <= '0;
          n_q[1] <= '0;
          n_q[2] <= NW'(smv_pkg::UNIT_ONE);
        end
        smv_pkg::ST_RD1: pa_q <= node_rdata;
        smv_pkg::ST_RD2: pb_q <= node_rdata;
        smv_pkg::ST_RD3: begin
          for (int i = 0; i < 3; i++) begin
            e_q[i]   <= EW'($signed(pb_q[i*32 +: 32])) - EW'($signed(pa_q[i*32 +: 32]));
            e_q[i+3] <= EW'($signed(node_rdata[i*32 +: 32])) - EW'($signed(pa_q[i*32 +: 32]));
          end
        end
        smv_pkg::ST_SCALE: begin
          if (big) begin
            for (int i = 0; i < 6; i++) begin
              e_q[i] <= e_q[i][EW-1] ? -((-e_q[i]) >>> 1) : (e_q[i] >>> 1);
            end
          end else begin
            cnt_q <= '0;
          end
        end
        smv_pkg::ST_CROSS: begin
          prod_q <= mul_a * mul_b;
          if (cnt_q != 5'd0) begin
            if (cnt_q[0]) v_q[cross_sel] <= VW'(prod_q);
            else v_q[cross_sel] <= v_q[cross_sel] - VW'(prod_q);
          end
          cnt_q <= cnt_q + 5'd1;
        end
        smv_pkg::ST_RDACC: begin
          for (int i = 0; i < 3; i++) begin
            v_q[i] <= VW'($signed(acc_rdata[i*AB +: AB]));
          end
        end
        smv_pkg::ST_UINIT: begin
          for (int i = 0; i < 3; i++) begin
            sgn_q[i] <= v_q[i][VW-1];
            m_q[i]   <= v_q[i][VW-1] ? VW'(-v_q[i]) : VW'(v_q[i]);
          end
        end
        smv_pkg::ST_NORM: begin
          for (int i = 0; i < 3; i++) begin
            if (mx >= VW'(64'd1 << 37)) m_q[i] <= m_q[i] >> 8;
            else if (mx >= VW'(64'd1 << 30)) m_q[i] <= m_q[i] >> 1;
            else if (mx < VW'(64'd1 << 21)) m_q[i] <= m_q[i] << 8;
            else if (mx < VW'(64'd1 << 29)) m_q[i] <= m_q[i] << 1;
          end
          cnt_q <= '0;
          sum_q <= '0;
        end
        smv_pkg::ST_SQ: begin
          prod_q <= mul_a * mul_b;
          if (cnt_q != 5'd0) sum_q <= sum_q + $unsigned(prod_q);
          cnt_q <= cnt_q + 5'd1;
          x_q   <= sum_q + $unsigned(prod_q);
          r_q   <= '0;
          bit_q <= 64'd1 << 62;
        end
        smv_pkg::ST_SQRT: begin
          if (x_q >= sq_try) begin
            x_q <= x_q - sq_try;
            r_q <= (r_q >> 1) + bit_q;
            if (bit_q == 64'd1) mag_q <= 32'((r_q >> 1) + bit_q);
          end else begin
            r_q <= r_q >> 1;
            if (bit_q == 64'd1) mag_q <= 32'(r_q >> 1);
          end
          bit_q <= bit_q >> 2;
        end
        smv_pkg::ST_DINIT: begin
          rem_q <= RW'({m_q[comp_q][29:0], 14'b0}) + RW'(mag_q >> 1);
          quo_q <= '0;
          cnt_q <= 5'(QW - 1);
        end
        smv_pkg::ST_DIV: begin
          if (rem_q >= div_d) begin
            rem_q        <= rem_q - div_d;
            quo_q[cnt_q[3:0]] <= 1'b1;
          end
          if (cnt_q == 5'd0) begin
            n_q[comp_q] <= sgn_q[comp_q] ? -NW'({quo_q[QW-1:1], rem_q >= div_d})
                                         : NW'({quo_q[QW-1:1], rem_q >= div_d});
            comp_q <= comp_q + 2'd1;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        smv_pkg::ST_ACC_WR: cnt_q <= cnt_q + 5'd1;
        smv_pkg::ST_RESULT: begin
          if (out_free) begin
            out_idx_q   <= idx_q;
            out_n_q     <= n_q;
          end
        end
        default: ;
      endcase
    end
  end

  smv_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  smv_ram #(.WIDTH(3*AB), .DEPTH(MAX_VERTICES)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign normal_index_o = out_idx_q;
  assign normal_x_o     = out_n_q[0];
  assign normal_y_o     = out_n_q[1];
  assign normal_z_o     = out_n_q[2];

endmodule

// ----- design/smv_ram.sv -----
// ----------------------------------------------------------------------------
// smv_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module smv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
